// ===== hdl/sdp_pkg.sv =====
// Package for the sACN data packet parser: result types, header offsets and constants.
`timescale 1ns / 1ps

package sdp_pkg;

  typedef enum logic {
    RESULT_SLOT    = 1'b0,
    RESULT_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic [15:0] universe_number;
    logic [9:0]  slot_total;
    logic        accepted;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic       check;
    logic [7:0] want;
  } hdr_check_t;

  localparam int unsigned OffsetW = 10;
  localparam logic [OffsetW-1:0] OffsetMax     = 10'd1023;
  localparam logic [OffsetW-1:0] OffOptions    = 10'd112;
  localparam logic [OffsetW-1:0] OffUniverseHi = 10'd113;
  localparam logic [OffsetW-1:0] OffUniverseLo = 10'd114;
  localparam logic [OffsetW-1:0] OffPropHi     = 10'd123;
  localparam logic [OffsetW-1:0] OffPropLo     = 10'd124;
  localparam logic [OffsetW-1:0] PayloadStart  = 10'd126;

  localparam logic [7:0] PreambleLo  = 8'h10;
  localparam logic [7:0] RootVector  = 8'h04;
  localparam logic [7:0] FrameVector = 8'h02;
  localparam logic [7:0] DmpVector   = 8'h02;
  localparam logic [7:0] DmpAddrType = 8'ha1;
  localparam logic [7:0] OptionMask  = 8'hc0;  // preview (0x80) | terminated (0x40)

  localparam logic [7:0] AcnIdent [12] = '{
    8'h41, 8'h53, 8'h43, 8'h2d, 8'h45, 8'h31, 8'h2e, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  // Fixed header bytes and the value each must hold.
  function automatic hdr_check_t expected_byte(input logic [OffsetW-1:0] off);
    hdr_check_t r;
    logic [3:0] idx;
    idx     = 4'(off - 10'd4);
    r.check = 1'b1;
    r.want  = 8'h00;
    case (off) inside
      10'd0:           r.want = 8'h00;
      10'd1:           r.want = PreambleLo;
      [10'd2:10'd3]:   r.want = 8'h00;
      [10'd4:10'd15]:  r.want = AcnIdent[idx];
      [10'd18:10'd20]: r.want = 8'h00;
      10'd21:          r.want = RootVector;
      [10'd40:10'd42]: r.want = 8'h00;
      10'd43:          r.want = FrameVector;
      10'd117:         r.want = DmpVector;
      10'd118:         r.want = DmpAddrType;
      10'd125:         r.want = 8'h00;
      default:         r.check = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sdp_byte_if.sv =====
// Input channel: one packet byte per item with its end-of-packet flag.
`timescale 1ns / 1ps

interface sdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

// ===== hdl/sdp_result_if.sv =====
// Output channel: one slot result or packet verdict per item.
`timescale 1ns / 1ps

interface sdp_result_if;
  logic          valid;
  logic          ready;
  sdp_pkg::kind_e result_kind;
  logic [8:0]    slot_index;
  logic [7:0]    slot_value;
  logic [15:0]   universe_number;
  logic [9:0]    slot_total;
  logic          accepted;
  logic          run_last;

  modport source (output valid, output result_kind, output slot_index, output slot_value,
                  output universe_number, output slot_total, output accepted,
                  output run_last, input ready);
  modport sink   (input valid, input result_kind, input slot_index, input slot_value,
                  input universe_number, input slot_total, input accepted,
                  input run_last, output ready);
endinterface

// ===== hdl/sacn_dmx_packet_parser.sv =====
// Top level of the streaming sACN (E1.31) data packet parser.
`timescale 1ns / 1ps
//
// Usage:
//  - byte_i takes the packet one byte per item from byte zero, end_of_packet
//    set on the final byte; the next byte starts a new packet.
//  - result_o gives a slot item (result_kind 0) for each payload byte from
//    offset 126 while the count stays below min(property count - 1, MAX_SLOTS),
//    and a verdict item (result_kind 1) after the final byte. run_last marks
//    the last item caused by one input byte.
//  - Header bytes are checked as they pass; any mismatch stops further slots
//    and rejects the packet in its verdict.
//  - Queue: a byte's results are written into a 4-entry result queue at the
//    edge that accepts it and show on result_o once the items ahead are taken.
//  - Throughput: one byte per cycle. A byte may cause two items (last slot plus
//    verdict); byte_i.ready drops while the queue has fewer than two free
//    entries, so the output port's one item per cycle sets the sustained rate.
//  - Reset clears the packet state (offset 0, headers good) and empties the
//    queue; byte_i.ready is high from reset on, since the queue is empty.
//  - A stalled receiver fills the queue and then holds byte_i.ready low; no
//    item is lost or repeated.
//
module sacn_dmx_packet_parser #(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sdp_byte_if.sink         byte_i,
  sdp_result_if.source     result_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam logic [9:0]  MaxSlots = 10'(MAX_SLOTS);

  // Packet state
  logic [9:0]  offset_q, offset_d;
  logic        good_q, good_d;
  logic [15:0] universe_q, universe_d;
  logic [15:0] prop_q, prop_d;
  logic [9:0]  sent_q, sent_d;

  // Result queue
  sdp_pkg::result_t fifo_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;

  logic             accept, pop;
  logic             emit_slot;
  logic             last;
  logic [7:0]       b;
  logic             verdict_acc;
  sdp_pkg::hdr_check_t hc;
  sdp_pkg::result_t slot_res, verdict_res;
  logic [PtrW:0]    push_n;

  assign b    = byte_i.packet_byte;
  assign last = byte_i.end_of_packet;

  assign byte_i.ready = (count_q <= (PtrW+1)'(Depth - 2));
  assign accept       = byte_i.valid & byte_i.ready;
  assign pop          = result_o.valid & result_o.ready;

  assign hc = sdp_pkg::expected_byte(offset_q);

  always_comb begin
    universe_d = universe_q;
    prop_d     = prop_q;
    good_d     = good_q;
    sent_d     = sent_q;
    emit_slot  = 1'b0;
    if (hc.check) begin
      if (b != hc.want) good_d = 1'b0;
    end else if (offset_q == sdp_pkg::OffOptions) begin
      if ((b & sdp_pkg::OptionMask) != 8'h00) good_d = 1'b0;
    end else if (offset_q == sdp_pkg::OffUniverseHi) begin
      universe_d = {b, universe_q[7:0]};
    end else if (offset_q == sdp_pkg::OffUniverseLo) begin
      universe_d = {universe_q[15:8], b};
    end else if (offset_q == sdp_pkg::OffPropHi) begin
      prop_d = {b, prop_q[7:0]};
    end else if (offset_q == sdp_pkg::OffPropLo) begin
      prop_d = {prop_q[15:8], b};
      if ({prop_q[15:8], b} == 16'h0000) good_d = 1'b0;
    end else if (offset_q >= sdp_pkg::PayloadStart && good_q && prop_q != 16'h0000) begin
      // sent < min(prop - 1, MAX_SLOTS)
      if (sent_q < MaxSlots && (17'(sent_q) + 17'd1) < 17'(prop_q)) begin
        emit_slot = 1'b1;
        sent_d    = sent_q + 10'd1;
      end
    end
  end

  assign verdict_acc = good_d && (sent_d != 10'd0);

  always_comb begin
    slot_res.result_kind     = sdp_pkg::RESULT_SLOT;
    slot_res.slot_index      = sent_q[8:0];
    slot_res.slot_value      = b;
    slot_res.universe_number = universe_d;
    slot_res.slot_total      = 10'd0;
    slot_res.accepted        = 1'b0;
    slot_res.run_last        = ~last;

    verdict_res.result_kind     = sdp_pkg::RESULT_VERDICT;
    verdict_res.slot_index      = 9'd0;
    verdict_res.slot_value      = 8'd0;
    verdict_res.universe_number = verdict_acc ? universe_d : 16'd0;
    verdict_res.slot_total      = verdict_acc ? sent_d : 10'd0;
    verdict_res.accepted        = verdict_acc;
    verdict_res.run_last        = 1'b1;
  end

  assign push_n = accept ? ((PtrW+1)'(emit_slot) + (PtrW+1)'(last)) : '0;

  // Packet state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      good_q     <= 1'b1;
      universe_q <= '0;
      prop_q     <= '0;
      sent_q     <= '0;
    end else if (accept) begin
      if (last) begin
        offset_q   <= '0;
        good_q     <= 1'b1;
        universe_q <= '0;
        prop_q     <= '0;
        sent_q     <= '0;
      end else begin
        if (offset_q < sdp_pkg::OffsetMax) offset_q <= offset_q + 10'd1;
        good_q     <= good_d;
        universe_q <= universe_d;
        prop_q     <= prop_d;
        sent_q     <= sent_d;
      end
    end
  end

  // Queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[PtrW-1:0];
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q  <= count_q + push_n - (PtrW+1)'(pop);
    end
  end

  // Queue storage; the slot goes first, the verdict after it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (emit_slot) fifo_q[wr_ptr_q] <= slot_res;
      if (last) fifo_q[wr_ptr_q + PtrW'(emit_slot)] <= verdict_res;
    end
  end

  assign result_o.valid           = (count_q != '0);
  assign result_o.result_kind     = fifo_q[rd_ptr_q].result_kind;
  assign result_o.slot_index      = fifo_q[rd_ptr_q].slot_index;
  assign result_o.slot_value      = fifo_q[rd_ptr_q].slot_value;
  assign result_o.universe_number = fifo_q[rd_ptr_q].universe_number;
  assign result_o.slot_total      = fifo_q[rd_ptr_q].slot_total;
  assign result_o.accepted        = fifo_q[rd_ptr_q].accepted;
  assign result_o.run_last        = fifo_q[rd_ptr_q].run_last;

endmodule

// ===== sim/sacn_dmx_packet_parser_checker.sv =====
// Result checker for the sACN parser: tracks accepted bytes, predicts results, compares.
`timescale 1ns / 1ps

module sacn_dmx_packet_parser_checker #(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdp_byte_if         byte_mon,
  sdp_result_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [9:0]          offset_q;
  logic                hdr_ok_q;
  logic [15:0]         universe_q;
  logic [15:0]         props_q;
  logic [9:0]          slots_q;
  sdp_pkg::result_t    expected_results[$];
  int unsigned         fail_count = 0;

  // 1 when the byte sits at a fixed header offset and differs from what it must hold.
  function automatic logic fixed_byte_bad(input logic [9:0] off, input logic [7:0] b);
    logic [7:0] want;
    logic       fixed;
    fixed = 1'b1;
    want  = 8'h00;
    if (off == 10'd1) want = sdp_pkg::PreambleLo;
    else if (off >= 10'd4 && off <= 10'd15) want = sdp_pkg::AcnIdent[4'(off - 10'd4)];
    else if (off == 10'd21) want = sdp_pkg::RootVector;
    else if (off == 10'd43) want = sdp_pkg::FrameVector;
    else if (off == 10'd117) want = sdp_pkg::DmpVector;
    else if (off == 10'd118) want = sdp_pkg::DmpAddrType;
    else if (!(off <= 10'd3 || (off >= 10'd18 && off <= 10'd20) ||
               (off >= 10'd40 && off <= 10'd42) || off == 10'd125)) fixed = 1'b0;
    return fixed && (b != want);
  endfunction

  task automatic clear_frame();
    offset_q   = '0;
    hdr_ok_q   = 1'b1;
    universe_q = '0;
    props_q    = '0;
    slots_q    = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eop);
    sdp_pkg::result_t slot_r;
    sdp_pkg::result_t verdict_r;
    logic             have_slot;
    int unsigned      slot_limit;
    have_slot = 1'b0;
    slot_r    = '0;
    verdict_r = '0;
    if (fixed_byte_bad(offset_q, b)) begin
      hdr_ok_q = 1'b0;
    end else if (offset_q == sdp_pkg::OffOptions) begin
      if ((b & sdp_pkg::OptionMask) != 8'h00) hdr_ok_q = 1'b0;
    end else if (offset_q == sdp_pkg::OffUniverseHi) begin
      universe_q[15:8] = b;
    end else if (offset_q == sdp_pkg::OffUniverseLo) begin
      universe_q[7:0] = b;
    end else if (offset_q == sdp_pkg::OffPropHi) begin
      props_q[15:8] = b;
    end else if (offset_q == sdp_pkg::OffPropLo) begin
      props_q[7:0] = b;
      if (props_q == 16'd0) hdr_ok_q = 1'b0;
    end else if (offset_q >= sdp_pkg::PayloadStart && hdr_ok_q && props_q != 16'd0) begin
      slot_limit = int'(props_q) - 1;
      if (slot_limit > MAX_SLOTS) slot_limit = MAX_SLOTS;
      if (slots_q < slot_limit) begin
        have_slot              = 1'b1;
        slot_r.result_kind     = sdp_pkg::RESULT_SLOT;
        slot_r.slot_index      = slots_q[8:0];
        slot_r.slot_value      = b;
        slot_r.universe_number = universe_q;
        slot_r.run_last        = !eop;
        slots_q                = slots_q + 10'd1;
      end
    end
    if (offset_q != sdp_pkg::OffsetMax) offset_q = offset_q + 10'd1;
    if (have_slot) expected_results.push_back(slot_r);
    if (eop) begin
      verdict_r.result_kind = sdp_pkg::RESULT_VERDICT;
      verdict_r.run_last    = 1'b1;
      if (hdr_ok_q && slots_q != 10'd0) begin
        verdict_r.universe_number = universe_q;
        verdict_r.slot_total      = slots_q;
        verdict_r.accepted        = 1'b1;
      end
      expected_results.push_back(verdict_r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    sdp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("result item with no expectation waiting (kind %0d)", int'(res_mon.result_kind));
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", int'(want.result_kind), int'(res_mon.result_kind));
      check_field("slot_index", 32'(want.slot_index), 32'(res_mon.slot_index));
      check_field("slot_value", 32'(want.slot_value), 32'(res_mon.slot_value));
      check_field("universe_number", 32'(want.universe_number), 32'(res_mon.universe_number));
      check_field("slot_total", 32'(want.slot_total), 32'(res_mon.slot_total));
      check_field("accepted", 32'(want.accepted), 32'(res_mon.accepted));
      check_field("run_last", 32'(want.run_last), 32'(res_mon.run_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      expected_results.delete();
    end else begin
      // A byte's results reach the queue only at the edge that takes it, so predicting first is safe.
      if (byte_mon.valid && byte_mon.ready) predict_byte(byte_mon.packet_byte,
                                                         byte_mon.end_of_packet);
      if (res_mon.valid && res_mon.ready) check_result();
    end
    pending_o    <= expected_results.size();
    fail_count_o <= fail_count;
  end

endmodule

// ===== sim/sacn_dmx_packet_parser_tb.sv =====
// Testbench top for the sACN parser: drives packet bytes and result back-pressure.
`timescale 1ns / 1ps

// Flow:
//  - reset first, then a directed set of frames: one-byte frame,
//    property count 1 (no slot allowed), property count 0, single max slot
//    on universe 0xffff, header-only frame, preview and terminated bits,
//    harmless option bits, bad ACN identifier, nonzero start code, and one
//    oversized frame that hits the 512-slot cap and the offset saturation.
//  - random frames in three phases of idling: sender 36% / receiver 55%,
//    then 55% / 36%, then none. Most frames are well formed with random
//    content and small property counts; the rest are noise or broken.
//  - during the last phase the receiver is held off for long stretches so
//    the result queue fills and the parser drops byte ready.
//  - the checker predicts every result; this module only stimulates and
//    gives the verdict.
module sacn_dmx_packet_parser_tb;

  localparam int unsigned MaxSlots    = 512;
  localparam int unsigned RandomBytes = 1850;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned TailCycles  = 8;

  // Offsets whose value is fixed by the protocol; used to break headers.
  localparam int unsigned FixedOffsets [29] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    18, 19, 20, 21, 40, 41, 42, 43, 117, 118, 125, 125, 1
  };

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned bytes_sent = 0;
  int unsigned fail_count;
  int unsigned pending_count;
  logic [7:0]  frame_bytes[$];

  sdp_byte_if   byte_ch ();
  sdp_result_if result_ch ();

  sacn_dmx_packet_parser #(
    .MAX_SLOTS (MaxSlots)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_i   (byte_ch),
    .result_o (result_ch)
  );

  sacn_dmx_packet_parser_checker #(
    .MAX_SLOTS (MaxSlots)
  ) result_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_mon     (byte_ch),
    .res_mon      (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang or a lost item ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sacn_dmx_packet_parser_tb NOT OK");
      $finish;
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one byte, with random idle cycles first, and returns at the edge that takes it.
  // ready is sampled on the falling edge, where nothing is in motion.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.packet_byte   <= b;
    byte_ch.end_of_packet <= eop;
    do begin
      @(negedge clk);
      taken = byte_ch.ready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Root, framing and DMP layers up to and including the start code;
  // unchecked fields (lengths, CID, source name, sequence...) are random.
  task automatic make_header(input logic [15:0] uni, input logic [15:0] props,
                             input logic [7:0] opts);
    int i;
    frame_bytes.delete();
    for (i = 0; i < 126; i++) frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes[0] = 8'h00;
    frame_bytes[1] = sdp_pkg::PreambleLo;
    frame_bytes[2] = 8'h00;
    frame_bytes[3] = 8'h00;
    for (i = 0; i < 12; i++) frame_bytes[4 + i] = sdp_pkg::AcnIdent[4'(i)];
    for (i = 18; i < 21; i++) frame_bytes[i] = 8'h00;
    frame_bytes[21] = sdp_pkg::RootVector;
    for (i = 40; i < 43; i++) frame_bytes[i] = 8'h00;
    frame_bytes[43]  = sdp_pkg::FrameVector;
    frame_bytes[112] = opts;
    frame_bytes[113] = uni[15:8];
    frame_bytes[114] = uni[7:0];
    frame_bytes[117] = sdp_pkg::DmpVector;
    frame_bytes[118] = sdp_pkg::DmpAddrType;
    frame_bytes[123] = props[15:8];
    frame_bytes[124] = props[7:0];
    frame_bytes[125] = 8'h00;
  endtask

  task automatic add_payload(input int unsigned count);
    repeat (count) frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Noise ~8%, broken ~20%, well formed otherwise. Payload is usually the exact
  // slot count, sometimes cut short, sometimes a few bytes too long.
  task automatic random_frame();
    int unsigned pick;
    int unsigned props;
    int unsigned len_pick;
    int unsigned keep;
    int unsigned spot;
    pick = $urandom_range(99);
    if (pick < 8) begin
      frame_bytes.delete();
      add_payload($urandom_range(1, 40));
    end else begin
      props = ($urandom_range(99) < 3) ? $urandom_range(500, 600) : $urandom_range(1, 24);
      make_header(16'($urandom), 16'(props), {2'b00, 6'($urandom)});
      len_pick = $urandom_range(99);
      if (len_pick < 70) add_payload(props - 1);
      else if (len_pick < 85) add_payload($urandom_range(0, props - 1));
      else add_payload(props - 1 + $urandom_range(1, 4));
      if (pick >= 80) begin
        case ($urandom_range(3))
          0: frame_bytes[112] = frame_bytes[112] | (8'h40 << $urandom_range(1));
          1: begin
            frame_bytes[123] = 8'h00;
            frame_bytes[124] = 8'h00;
          end
          2: begin
            spot = FixedOffsets[5'($urandom_range(28))];
            frame_bytes[spot] = frame_bytes[spot] ^ 8'($urandom_range(1, 255));
          end
          default: begin
            keep = $urandom_range(1, 125);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    int unsigned frame_count;
    byte_ch.valid         = 1'b0;
    byte_ch.packet_byte   = 8'h00;
    byte_ch.end_of_packet = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 55;

    // One-byte frame: rejected before any header is seen.
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    send_frame();
    // Property count 1 leaves room for the start code only: no slot, rejected.
    make_header(16'h0000, 16'd1, 8'h00);
    add_payload(3);
    send_frame();
    // Zero property count counts as a bad header.
    make_header(16'h1234, 16'd0, 8'h00);
    add_payload(2);
    send_frame();
    // One slot at full level on the top universe.
    make_header(16'hffff, 16'd2, 8'h00);
    frame_bytes.push_back(8'hff);
    send_frame();
    // Header only, ends on the start code.
    make_header(16'h0007, 16'd5, 8'h00);
    send_frame();
    // Preview, then stream terminated.
    make_header(16'h0001, 16'd3, 8'h80);
    add_payload(2);
    send_frame();
    make_header(16'h0001, 16'd3, 8'h40);
    add_payload(2);
    send_frame();
    // Low option bits are don't-care.
    make_header(16'h00ff, 16'd4, 8'h3f);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h55);
    frame_bytes.push_back(8'haa);
    send_frame();
    // Broken ACN identifier.
    make_header(16'h0002, 16'd3, 8'h00);
    frame_bytes[10] = frame_bytes[10] ^ 8'h01;
    add_payload(2);
    send_frame();
    // Alternate start code.
    make_header(16'h0002, 16'd3, 8'h00);
    frame_bytes[125] = 8'hcc;
    add_payload(2);
    send_frame();
    // Oversized: 512-slot cap, then bytes past offset 1023.
    make_header(16'h8001, 16'hffff, 8'h00);
    add_payload(1000);
    send_frame();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target      = bytes_sent + RandomBytes / 3;
      frame_count = 0;
      while (bytes_sent < target) begin
        // Full-rate sender against a stalled receiver: queue fills, ready drops.
        if (phase == 2 && frame_count % 4 == 0) hold_requests++;
        random_frame();
        send_frame();
        frame_count++;
      end
    end
    byte_ch.valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (TailCycles) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("sacn_dmx_packet_parser_tb OK");
    end else begin
      $display("sacn_dmx_packet_parser_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sdp_pkg.sv
hdl/sdp_byte_if.sv
hdl/sdp_result_if.sv
hdl/sacn_dmx_packet_parser.sv
sim/sacn_dmx_packet_parser_checker.sv
sim/sacn_dmx_packet_parser_tb.sv
